[rtl/cbo_pkg.sv]
package cbo_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_M1_W   = $clog2(MAX_HEIGHT);
  // rows run on past the frame while the last outputs are flushed
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);

  localparam int COLOUR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } rgb_t;

  localparam rgb_t BORDER_RGB = '{red: '0, green: '0, blue: '1};

  // one entry of the line store: flags of the two rows above and the colour
  // of the row above
  typedef struct packed {
    logic upper;
    logic lower;
    rgb_t colour;
  } line_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_word_t       word;
  } line_wr_t;

  // one window step, as issued at the input
  typedef struct packed {
    logic             write;
    logic             flag;
    rgb_t             colour;
    logic [COL_W-1:0] col;
    logic             c_zero;
    logic             emit;
    logic             top;
    logic             bot;
    logic             left_edge;
    logic             right_edge;
    logic             restart;
  } step_op_t;

  typedef struct packed {
    rgb_t colour;
    logic on_border;
    logic frame_end;
  } result_t;

endpackage

[rtl/cbo_pix_if.sv]
interface cbo_pix_if;
  import cbo_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                level_inside;

  modport source (output valid, kind, red, green, blue, level_inside, input ready);
  modport sink   (input valid, kind, red, green, blue, level_inside, output ready);

endinterface

[rtl/cbo_res_if.sv]
interface cbo_res_if;
  import cbo_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] out_red;
  logic [COLOUR_W-1:0] out_green;
  logic [COLOUR_W-1:0] out_blue;
  logic                on_border;
  logic                frame_end;

  modport source (output valid, out_red, out_green, out_blue, on_border, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, on_border, frame_end,
                  output ready);

endinterface

[rtl/cbo_cfg_if.sv]
interface cbo_cfg_if;
  import cbo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

[rtl/cbo_line_store.sv]
module cbo_line_store (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [cbo_pkg::COL_W-1:0] rd_addr_i,
  input  cbo_pkg::line_wr_t        wr_i,
  output cbo_pkg::line_word_t      rd_word_o
);
  import cbo_pkg::*;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.word;
    end
    if (rd_en_i) begin
      // a step that reads the column being written in that cycle sees the fresh entry
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_q <= wr_i.word;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_word_o = rd_q;

endmodule

[rtl/cbo_border.sv]
module cbo_border (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  cbo_pkg::step_op_t   op_i,
  input  cbo_pkg::line_word_t word_i,
  output cbo_pkg::result_t    res_o,
  output cbo_pkg::line_wr_t   wr_o
);
  import cbo_pkg::*;

  logic [8:0] win_q, win_d;
  rgb_t       hold_q, hold_d;

  logic [2:0] column, left, centre, right;
  logic [2:0] left_c, centre_c, right_c;
  logic [8:0] win_shift;
  logic       border;

  // replicate the middle row over a missing row above or below
  function automatic logic [2:0] clamp_rows(logic [2:0] col, logic top, logic bot);
    logic [2:0] r;
    r = col;
    if (top) r[0] = col[1];
    if (bot) r[2] = col[1];
    return r;
  endfunction

  always_comb begin
    column    = {op_i.flag, word_i.lower, word_i.upper};
    win_shift = {column, win_q[8:3]};
    if (op_i.c_zero) begin
      // row just ended: the window still holds the last two columns
      left   = win_q[5:3];
      centre = win_q[8:6];
      right  = win_q[8:6];
    end else begin
      left   = win_shift[2:0];
      centre = win_shift[5:3];
      right  = win_shift[8:6];
    end
    if (op_i.left_edge)  left  = centre;
    if (op_i.right_edge) right = centre;
    left_c   = clamp_rows(left, op_i.top, op_i.bot);
    centre_c = clamp_rows(centre, op_i.top, op_i.bot);
    right_c  = clamp_rows(right, op_i.top, op_i.bot);
    border   = centre_c[1] && ({right_c, centre_c, left_c} != '1);
  end

  always_comb begin
    res_o.colour    = border ? BORDER_RGB : hold_q;
    res_o.on_border = border;
    res_o.frame_end = op_i.bot && op_i.right_edge;
  end

  always_comb begin
    wr_o.en          = step_i && op_i.write;
    wr_o.addr        = op_i.col;
    wr_o.word.upper  = word_i.lower;
    wr_o.word.lower  = op_i.flag;
    wr_o.word.colour = op_i.colour;
  end

  always_comb begin
    win_d  = win_q;
    hold_d = hold_q;
    if (clear_i) begin
      win_d  = '0;
      hold_d = '0;
    end else if (step_i) begin
      win_d  = op_i.restart ? '0 : win_shift;
      hold_d = op_i.restart ? '0 : word_i.colour;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      hold_q <= '0;
    end else begin
      win_q  <= win_d;
      hold_q <= hold_d;
    end
  end

endmodule

[rtl/contour_border_overlay_unit.sv]
// Border overlay for a raster RGB stream with a per-pixel region flag.
// in_i takes one transaction per pixel (kind = pixel) in raster order, or a
// flush (kind = flush) that releases one of the outputs still held after the
// last pixel of a frame. out_o carries one output pixel per transaction: the
// input colour, or pure blue with on_border set where the flag is set and a
// neighbour (edge replicated) is clear; frame_end marks the last of a frame.
// The output for raster position p is produced by the transaction of
// position p+width+1, or by a flush once the frame is complete: width+1
// flushes per frame, width when the frame has one row. Pixels sent while
// flushes are owed are dropped. Outputs pass the step and output registers.
// Throughput is one transaction per cycle while the skid entry is free; the
// last pixel of a one-row frame holds in_i.ready low for a silent fill step.
// cfg_i writes frame_width (index 0) and frame_height (index 1); a write to
// either restarts the frame, other indices are ignored; cfg_i.ready is always
// high. Reset gives 1024 x 1024 and a fresh frame; the line store is not
// cleared and needs no clearing pass.
// A stalled out_o fills a two-entry output buffer, then in_i.ready drops
// until the receiver takes a transaction.
module contour_border_overlay_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  cbo_pix_if.sink   in_i,
  cbo_res_if.source out_o,
  cbo_cfg_if.sink   cfg_i
);
  import cbo_pkg::*;

  logic [COL_W-1:0]    w_m1_q, w_m1_d;
  logic [ROW_M1_W-1:0] h_m1_q, h_m1_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [PEND_W-1:0]   pend_q, pend_d;
  logic                fill_q, fill_d;

  logic                s1_valid_q;
  step_op_t            s1_q, op_d;

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  result_t             out_q, skid_q, res;

  logic       en, in_ready, accept, is_pixel, pend_zero;
  logic       issue_fill, issue_pix, issue_flush, issue;
  logic       c_zero, last_pix, cfg_wr, cfg_hit, step, push, pop;
  logic       load_out, load_skid;
  line_word_t rd_word;
  line_wr_t   wr;

  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  // only a write to a real register restarts the frame
  assign cfg_hit     = cfg_wr && ((cfg_i.index == REG_FRAME_WIDTH) ||
                                  (cfg_i.index == REG_FRAME_HEIGHT));

  // the pipeline moves while the skid entry is free
  assign en        = !skid_valid_q;
  assign in_ready  = en && !fill_q;
  assign in_i.ready = in_ready;
  assign accept    = in_i.valid && in_ready;
  assign is_pixel  = (in_i.kind == KIND_PIXEL);
  assign pend_zero = (pend_q == '0);

  assign issue_fill  = en && fill_q;
  assign issue_pix   = accept && is_pixel && pend_zero;
  assign issue_flush = accept && !is_pixel && !pend_zero;
  assign issue       = issue_fill || issue_pix || issue_flush;

  assign c_zero   = (col_q == '0);
  assign last_pix = (row_q == ROW_W'(h_m1_q)) && (col_q == w_m1_q);

  // window position of the pixel that this step completes
  always_comb begin
    op_d.write        = issue_pix;
    op_d.flag         = issue_pix && in_i.level_inside;
    op_d.colour.red   = in_i.red;
    op_d.colour.green = in_i.green;
    op_d.colour.blue  = in_i.blue;
    op_d.col          = col_q;
    op_d.c_zero       = c_zero;
    op_d.emit         = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !c_zero);
    op_d.top          = c_zero ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
    op_d.bot          = c_zero ? (row_q == ROW_W'(h_m1_q) + ROW_W'(2))
                               : (row_q == ROW_W'(h_m1_q) + ROW_W'(1));
    op_d.left_edge    = c_zero ? (w_m1_q == '0) : (col_q == COL_W'(1));
    op_d.right_edge   = c_zero;
    op_d.restart      = issue_flush && (pend_q == PEND_W'(1));
  end

  always_comb begin
    w_m1_d = w_m1_q;
    h_m1_d = h_m1_q;
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    fill_d = fill_q;
    if (cfg_wr) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH: begin
          if (cfg_i.data == '0) begin
            w_m1_d = '0;
          end else if (int'(cfg_i.data) > MAX_WIDTH) begin
            w_m1_d = COL_W'(MAX_WIDTH - 1);
          end else begin
            w_m1_d = COL_W'(cfg_i.data - CFG_DATA_W'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_i.data == '0) begin
            h_m1_d = '0;
          end else if (int'(cfg_i.data) > MAX_HEIGHT) begin
            h_m1_d = ROW_M1_W'(MAX_HEIGHT - 1);
          end else begin
            h_m1_d = ROW_M1_W'(cfg_i.data - CFG_DATA_W'(1));
          end
        end
        default: ;
      endcase
    end
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
      fill_d = 1'b0;
    end else if (issue) begin
      if (col_q == w_m1_q) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
      if (issue_fill) begin
        fill_d = 1'b0;
      end
      if (issue_pix && last_pix) begin
        pend_d = PEND_W'(w_m1_q) + ((h_m1_q != '0) ? PEND_W'(2) : PEND_W'(1));
        // a one-row frame needs one silent step before the first flush output
        fill_d = (h_m1_q == '0);
      end
      if (issue_flush) begin
        pend_d = pend_q - PEND_W'(1);
        if (pend_q == PEND_W'(1)) begin
          col_d = '0;
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q     <= COL_W'(MAX_WIDTH - 1);
      h_m1_q     <= ROW_M1_W'(MAX_HEIGHT - 1);
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      fill_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      w_m1_q <= w_m1_d;
      h_m1_q <= h_m1_d;
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      fill_q <= fill_d;
      if (en) begin
        s1_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= op_d;
    end
  end

  cbo_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (issue),
    .rd_addr_i (col_q),
    .wr_i      (wr),
    .rd_word_o (rd_word)
  );

  assign step = en && s1_valid_q;

  cbo_border u_border (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (cfg_hit),
    .op_i    (s1_q),
    .word_i  (rd_word),
    .res_o   (res),
    .wr_o    (wr)
  );

  // two-entry output buffer
  assign push = step && s1_q.emit;
  assign pop  = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        skid_valid_d = 1'b0;
        load_out     = 1'b1;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        load_out    = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
        load_skid    = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_red   = out_q.colour.red;
  assign out_o.out_green = out_q.colour.green;
  assign out_o.out_blue  = out_q.colour.blue;
  assign out_o.on_border = out_q.on_border;
  assign out_o.frame_end = out_q.frame_end;

endmodule
